>>> rtl/core/gcm_pkg.sv
// gcm_pkg: shared types and constants of the ghash tag engine
// no dependencies; used by the multiplier, the top level and the tag checker
package gcm_pkg;

  localparam int unsigned BLOCK_BITS  = 128;
  localparam int unsigned BLOCK_BYTES = 16;
  localparam int unsigned DIGIT_BITS  = 8;
  localparam int unsigned DIGIT_STEPS = BLOCK_BITS / DIGIT_BITS;
  localparam int unsigned STEP_W      = $clog2(DIGIT_STEPS);
  localparam int unsigned HALF_BITS   = 64;
  localparam int unsigned CNT_BITS    = 5;

  // reduction constant 0xE1 followed by 120 zero bits
  localparam logic [7:0]            GCM_RED  = 8'hE1;
  localparam logic [BLOCK_BITS-1:0] RED_POLY = {GCM_RED, {(BLOCK_BITS-8){1'b0}}};

  typedef enum logic [1:0] {
    OP_AAD    = 2'd0,
    OP_TEXT   = 2'd1,
    OP_FINISH = 2'd2
  } op_e;

  typedef enum logic {
    CFG_SUBKEY_HIGH = 1'b0,
    CFG_SUBKEY_LOW  = 1'b1
  } cfg_idx_e;

  typedef logic [BLOCK_BITS-1:0] block_t;

endpackage

>>> rtl/core/gcm_ifs.sv
// gcm_ifs: valid/ready channel interfaces of the ghash tag engine
// no dependencies
interface gcm_blk_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [63:0] block_high;
  logic [63:0] block_low;
  logic [4:0]  byte_count;

  modport source (output valid, operation, block_high, block_low, byte_count, input ready);
  modport sink   (input valid, operation, block_high, block_low, byte_count, output ready);
endinterface

interface gcm_tag_if;
  logic        valid;
  logic        ready;
  logic [63:0] tag_high;
  logic [63:0] tag_low;

  modport source (output valid, tag_high, tag_low, input ready);
  modport sink   (input valid, tag_high, tag_low, output ready);
endinterface

>>> rtl/core/gcm_gf_mult.sv
// gcm_gf_mult: digit-serial gf(2^128) multiplier, gcm bit order
// depends on gcm_pkg
module gcm_gf_mult import gcm_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start_i,
  input  block_t x_i,
  input  block_t h_i,
  output logic   done_o,
  output block_t z_o
);

  block_t x_q, x_d;
  block_t v_q, v_d;
  block_t z_q, z_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;

  // one digit of x per cycle, msb first
  always_comb begin
    block_t v_n;
    block_t z_n;
    v_n    = v_q;
    z_n    = z_q;
    for (int j = 0; j < DIGIT_BITS; j++) begin
      if (x_q[BLOCK_BITS-1-j]) begin
        z_n = z_n ^ v_n;
      end
      v_n = {1'b0, v_n[BLOCK_BITS-1:1]} ^ (v_n[0] ? RED_POLY : '0);
    end
    x_d    = x_q;
    v_d    = v_q;
    z_d    = z_q;
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      x_d    = x_i;
      v_d    = h_i;
      z_d    = '0;
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      x_d   = {x_q[BLOCK_BITS-1-DIGIT_BITS:0], {DIGIT_BITS{1'b0}}};
      v_d   = v_n;
      z_d   = z_n;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == STEP_W'(DIGIT_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    v_q <= v_d;
    z_q <= z_d;
  end

  assign done_o = done_q;
  assign z_o    = z_q;

endmodule

>>> rtl/core/gcm_ghash_tag_engine.sv
// gcm_ghash_tag_engine: ghash accumulator, bit counts and tag output register
// depends on gcm_pkg, gcm_ifs and gcm_gf_mult
//
// GCM authentication engine. Each input word absorbs one 128-bit block of AAD
// (operation 0) or text (operation 1), keeping its leading byte_count bytes
// (saturated at 16) and zeroing the rest, or finishes the message (operation 2)
// with block_high/block_low carrying the mask E_K(J0). Absorbing XORs the block
// into the accumulator and multiplies by H; finishing XORs the length block
// {aad bits, text bits}, multiplies once more and emits accumulator ^ mask as
// one tag word, then clears accumulator and counts. Operation 3 and absorbs
// with a zero byte count are dropped in the accepting cycle. The user must
// write H through the config port (index 0 upper half, index 1 lower half)
// only while idle; the engine does not enforce it. An absorb or finish holds
// ready low until the 8-bit digit-serial GF multiplier has loaded, run all
// 16 digits and completed. A finish then moves the tag via the emit state
// into the output register, which holds it while the next message is absorbed;
// a following finish waits there only if the previous tag is still not taken.
module gcm_ghash_tag_engine import gcm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [63:0]      cfg_wdata_i,
  gcm_blk_if.sink          data_i,
  gcm_tag_if.source        tag_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MUL  = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  state_e state_q, state_d;

  // hash subkey
  logic [HALF_BITS-1:0] h_hi_q, h_lo_q;

  // ghash state
  block_t               acc_q, acc_d;
  logic [HALF_BITS-1:0] aad_q, aad_d;
  logic [HALF_BITS-1:0] text_q, text_d;
  logic                 fin_q, fin_d;
  block_t               mask_q, mask_d;

  // output word register
  logic   out_vld_q, out_vld_d;
  block_t tag_q, tag_d;

  // multiplier handshake
  logic   mul_start;
  block_t mul_x;
  logic   mul_done;
  block_t mul_z;

  logic                accept;
  logic [CNT_BITS-1:0] n_sat;
  block_t              blk;
  block_t              byte_mask;
  logic [HALF_BITS-1:0] bit_add;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_hi_q <= '0;
      h_lo_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SUBKEY_HIGH: h_hi_q <= cfg_wdata_i;
        CFG_SUBKEY_LOW:  h_lo_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign data_i.ready = (state_q == ST_IDLE);
  assign accept       = data_i.valid && data_i.ready;
  assign blk          = {data_i.block_high, data_i.block_low};

  // byte count saturates at a full block
  assign n_sat   = (data_i.byte_count > CNT_BITS'(BLOCK_BYTES)) ?
                   CNT_BITS'(BLOCK_BYTES) : data_i.byte_count;
  assign bit_add = {{(HALF_BITS-CNT_BITS-3){1'b0}}, n_sat, 3'b000};

  // leading bytes kept, byte 0 in the top bits
  always_comb begin
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      byte_mask[BLOCK_BITS-1-DIGIT_BITS*i -: DIGIT_BITS] =
        (CNT_BITS'(i) < n_sat) ? {DIGIT_BITS{1'b1}} : '0;
    end
  end

  always_comb begin
    state_d   = state_q;
    acc_d     = acc_q;
    aad_d     = aad_q;
    text_d    = text_q;
    fin_d     = fin_q;
    mask_d    = mask_q;
    out_vld_d = out_vld_q && !tag_o.ready;
    tag_d     = tag_q;
    mul_start = 1'b0;
    mul_x     = acc_q ^ (blk & byte_mask);

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (data_i.operation) inside
            OP_AAD, OP_TEXT: begin
              if (n_sat != '0) begin
                mul_start = 1'b1;
                fin_d     = 1'b0;
                state_d   = ST_MUL;
                if (data_i.operation == OP_AAD) begin
                  aad_d = aad_q + bit_add;
                end else begin
                  text_d = text_q + bit_add;
                end
              end
            end
            OP_FINISH: begin
              // length block goes in, counts restart for the next message
              mul_x     = acc_q ^ {aad_q, text_q};
              mul_start = 1'b1;
              mask_d    = blk;
              fin_d     = 1'b1;
              aad_d     = '0;
              text_d    = '0;
              state_d   = ST_MUL;
            end
            default: ;
          endcase
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          acc_d   = mul_z;
          state_d = fin_q ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        // wait for the output register to free up
        if (!out_vld_q || tag_o.ready) begin
          tag_d     = acc_q ^ mask_q;
          out_vld_d = 1'b1;
          acc_d     = '0;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      acc_q     <= '0;
      aad_q     <= '0;
      text_q    <= '0;
      fin_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      acc_q     <= acc_d;
      aad_q     <= aad_d;
      text_q    <= text_d;
      fin_q     <= fin_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mask_q <= mask_d;
    tag_q  <= tag_d;
  end

  gcm_gf_mult u_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .x_i     (mul_x),
    .h_i     ({h_hi_q, h_lo_q}),
    .done_o  (mul_done),
    .z_o     (mul_z)
  );

  assign tag_o.valid    = out_vld_q;
  assign tag_o.tag_high = tag_q[BLOCK_BITS-1:HALF_BITS];
  assign tag_o.tag_low  = tag_q[HALF_BITS-1:0];

endmodule

>>> rtl/core/gcm_tag_chk.sv
// gcm_tag_chk: port-level checks of the ghash tag engine, bound to the top level
// depends on gcm_pkg and gcm_ghash_tag_engine
module gcm_tag_chk import gcm_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic [1:0]  operation_i,
  input logic [4:0]  byte_count_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [63:0] tag_high_i,
  input logic [63:0] tag_low_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // stalled tag word stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("tag word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(tag_high_i) && $stable(tag_low_i))
    else $error("tag word changed while stalled");

  // a word that starts a multiply blocks the input next cycle
  a_busy_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (operation_i == OP_FINISH ||
               ((operation_i == OP_AAD || operation_i == OP_TEXT) && byte_count_i != '0))
    |=> !in_ready_i)
    else $error("input accepted during multiply");

  // a tag never appears right after an accept
  a_tag_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_acc))
    else $error("tag word too early");

endmodule

bind gcm_ghash_tag_engine gcm_tag_chk u_tag_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (data_i.valid),
  .in_ready_i   (data_i.ready),
  .operation_i  (data_i.operation),
  .byte_count_i (data_i.byte_count),
  .out_valid_i  (tag_o.valid),
  .out_ready_i  (tag_o.ready),
  .tag_high_i   (tag_o.tag_high),
  .tag_low_i    (tag_o.tag_low)
);
